@@ rtl/tga_rle_pixel_decoder_unit_macros.svh @@
// Assertion macros shared by the run-length pixel decoder modules.
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_MACROS_SVH

`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define TGAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
// Check that cons holds in the cycle after ante.
`define TGAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define TGAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TGAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/tgar_pkg.sv @@
// Shared types, constants and helpers of the run-length pixel decoder.
package tgar_pkg;

	// Field and register widths
	localparam int LW_W   = 13;
	localparam int LW_MAX = (1 << LW_W) - 1;
	localparam int CNT_W  = 8;
	localparam int COL_OUT_W = 12;

	// Line width limits
	localparam int MIN_LINE_WIDTH     = 64;
	localparam int DEF_MAX_LINE_WIDTH = 4096;

	// Register indexes
	localparam logic [1:0] CFG_PIXEL_FORMAT  = 2'd0;
	localparam logic [1:0] CFG_LINE_WIDTH    = 2'd1;
	localparam logic [1:0] CFG_VISIBLE_WIDTH = 2'd2;

	// Pixel format codes
	localparam logic [1:0] FMT_RGB555 = 2'd0;
	localparam logic [1:0] FMT_BGR    = 2'd1;
	localparam logic [1:0] FMT_BGRA   = 2'd2;

	// Register reset values
	localparam logic [1:0]      RST_PIXEL_FORMAT  = FMT_BGR;
	localparam logic [LW_W-1:0] RST_LINE_WIDTH    = 13'd640;
	localparam logic [LW_W-1:0] RST_VISIBLE_WIDTH = 13'd640;

	// Packet header layout
	localparam int HDR_RUN_BIT = 7;
	localparam logic [6:0] HDR_LEN_MASK = 7'h7F;

	// Parser phase
	typedef enum logic {
		PH_HEADER,
		PH_BODY
	} phase_t;

	// One decoded pixel with its repeat count
	typedef struct packed {
		logic [7:0]       blue;
		logic [7:0]       green;
		logic [7:0]       red;
		logic [CNT_W-1:0] count;
	} job_t;

	// Stored bytes per pixel; the spare code behaves as 32-bit
	function automatic logic [2:0] bytes_per_pixel(input logic [1:0] fmt);
		logic [2:0] n;
		unique case (fmt)
			FMT_RGB555: n = 3'd2;
			FMT_BGR:    n = 3'd3;
			default:    n = 3'd4;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/tgar_unpack.sv @@
// Packet header parser and pixel byte assembler.
module tgar_unpack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           stream_byte,
	input  logic [1:0]           pixel_format,
	input  logic                 job_busy,
	output logic                 job_load,
	output tgar_pkg::job_t       job
);

	tgar_pkg::phase_t phase_q, phase_d;
	logic [tgar_pkg::CNT_W-1:0] pkt_q, pkt_d;
	logic                       run_q, run_d;
	logic [1:0]                 bidx_q, bidx_d;
	logic [23:0]                pix_q, pix_d, pix_w;
	logic                       pix_done;
	logic                       accept;
	logic [15:0]                w16;

	// Merge the current word into the stored pixel bytes
	always_comb begin
		pix_w = pix_q;
		case (bidx_q)
			2'd0:    pix_w[7:0]   = stream_byte;
			2'd1:    pix_w[15:8]  = stream_byte;
			2'd2:    pix_w[23:16] = stream_byte;
			default: pix_w = pix_q;
		endcase
	end

	// Decode completion and handshake
	always_comb begin
		pix_done = (phase_q == tgar_pkg::PH_BODY) &&
			(({1'b0, bidx_q} + 3'd1) >= tgar_pkg::bytes_per_pixel(pixel_format));
		in_stall = pix_done & job_busy;
		accept   = in_valid & ~in_stall;
		job_load = accept & pix_done;
	end

	// Build the pixel colour and its count
	always_comb begin
		w16 = pix_w[15:0];
		if (pixel_format == tgar_pkg::FMT_RGB555) begin
			job.red   = {w16[14:10], 3'b000};
			job.green = {w16[9:5], 3'b000};
			job.blue  = {w16[4:0], 3'b000};
		end else begin
			job.blue  = pix_w[7:0];
			job.green = pix_w[15:8];
			job.red   = pix_w[23:16];
		end
		job.count = run_q ? pkt_q : tgar_pkg::CNT_W'(1);
	end

	// Next state
	always_comb begin
		phase_d = phase_q;
		pkt_d   = pkt_q;
		run_d   = run_q;
		bidx_d  = bidx_q;
		pix_d   = pix_q;
		if (accept) begin
			unique case (phase_q)
				tgar_pkg::PH_HEADER: begin
					run_d   = stream_byte[tgar_pkg::HDR_RUN_BIT];
					pkt_d   = {1'b0, stream_byte[6:0] & tgar_pkg::HDR_LEN_MASK} +
						tgar_pkg::CNT_W'(1);
					bidx_d  = 2'd0;
					phase_d = tgar_pkg::PH_BODY;
				end
				tgar_pkg::PH_BODY: begin
					pix_d = pix_w;
					if (!pix_done) begin
						bidx_d = bidx_q + 2'd1;
					end else begin
						bidx_d = 2'd0;
						if (run_q || pkt_q == '0) begin
							pkt_d = '0;
						end else begin
							pkt_d = pkt_q - tgar_pkg::CNT_W'(1);
						end
						if (pkt_d == '0) begin
							phase_d = tgar_pkg::PH_HEADER;
						end
					end
				end
				default: phase_d = tgar_pkg::PH_HEADER;
			endcase
		end
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tgar_pkg::PH_HEADER;
			pkt_q   <= '0;
			run_q   <= 1'b0;
			bidx_q  <= 2'd0;
			pix_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pkt_q   <= pkt_d;
			run_q   <= run_d;
			bidx_q  <= bidx_d;
			pix_q   <= pix_d;
		end
	end

endmodule

@@ rtl/tgar_segment.sv @@
// Line splitter: turns one pixel run into segments and holds the result register.
`include "tga_rle_pixel_decoder_unit_macros.svh"

module tgar_segment #(
	parameter int MAX_LINE_WIDTH = tgar_pkg::DEF_MAX_LINE_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [tgar_pkg::LW_W-1:0]        line_width,
	input  logic [tgar_pkg::LW_W-1:0]        visible_width,
	input  logic                             job_load,
	input  tgar_pkg::job_t                   job,
	output logic                             job_busy,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       blue,
	output logic [7:0]                       green,
	output logic [7:0]                       red,
	output logic [tgar_pkg::COL_OUT_W-1:0]   start_column,
	output logic [tgar_pkg::CNT_W-1:0]       pixel_count,
	output logic [tgar_pkg::CNT_W-1:0]       visible_count,
	output logic                             line_end,
	output logic                             last
);

	localparam int LW_W    = tgar_pkg::LW_W;
	localparam int EFF_MAX = (MAX_LINE_WIDTH > tgar_pkg::LW_MAX) ?
		tgar_pkg::LW_MAX : MAX_LINE_WIDTH;
	localparam int COL_W   = $clog2(EFF_MAX);

	logic                       job_vld_s1;
	tgar_pkg::job_t             job_s1;
	logic [tgar_pkg::CNT_W-1:0] rem_s1;
	logic [COL_W-1:0]           col_q;
	logic                       out_vld_q;

	logic [LW_W-1:0] width, col_ext, c0, room, n13, seg13, vis_room, vis13, col_nxt;
	logic            seg_fire, seg_end, seg_last;

	// Clamp the line width and cut the next segment
	always_comb begin
		if (line_width < LW_W'(tgar_pkg::MIN_LINE_WIDTH)) begin
			width = LW_W'(tgar_pkg::MIN_LINE_WIDTH);
		end else if (line_width > LW_W'(EFF_MAX)) begin
			width = LW_W'(EFF_MAX);
		end else begin
			width = line_width;
		end
		col_ext  = LW_W'(col_q);
		c0       = (col_ext >= width) ? '0 : col_ext;
		room     = width - c0;
		n13      = LW_W'(rem_s1);
		seg13    = (n13 < room) ? n13 : room;
		vis_room = visible_width - c0;
		if (visible_width > c0) begin
			vis13 = (vis_room < seg13) ? vis_room : seg13;
		end else begin
			vis13 = '0;
		end
		seg_end  = (seg13 == room);
		seg_last = (n13 == seg13);
		col_nxt  = seg_end ? '0 : c0 + seg13;
	end

	// Advance when the result register is free or being drained
	always_comb begin
		seg_fire = job_vld_s1 & (~out_vld_q | ~out_stall);
		job_busy = job_vld_s1 & ~(seg_fire & seg_last);
	end

	// Hold the pending run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_s1 <= 1'b0;
		end else if (job_load) begin
			job_vld_s1 <= 1'b1;
		end else if (seg_fire && seg_last) begin
			job_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			job_s1 <= job;
			rem_s1 <= job.count;
		end else if (seg_fire) begin
			rem_s1 <= rem_s1 - seg13[tgar_pkg::CNT_W-1:0];
		end
	end

	// Track the column of the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (seg_fire) begin
			col_q <= col_nxt[COL_W-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (seg_fire) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seg_fire) begin
			blue          <= job_s1.blue;
			green         <= job_s1.green;
			red           <= job_s1.red;
			start_column  <= c0[tgar_pkg::COL_OUT_W-1:0];
			pixel_count   <= seg13[tgar_pkg::CNT_W-1:0];
			visible_count <= vis13[tgar_pkg::CNT_W-1:0];
			line_end      <= seg_end;
			last          <= seg_last;
		end
	end

	assign out_valid = out_vld_q;

	`TGAR_ASSERT_IMP(a_count_nonzero, clk, arst_n, out_vld_q, pixel_count != '0)
	`TGAR_ASSERT_IMP(a_vis_in_seg, clk, arst_n, out_vld_q, visible_count <= pixel_count)
	`TGAR_ASSERT_NXT(a_col_wrap, clk, arst_n, seg_fire && seg_end, col_q == '0)
	`TGAR_ASSERT_NXT(a_run_held, clk, arst_n, seg_fire && !seg_last, job_vld_s1)

endmodule

@@ rtl/tga_rle_pixel_decoder_unit.sv @@
// Top level of the run-length pixel decoder: register file and datapath.
//
// Input channel: one compressed stream word per transfer on stream_byte, taken at
// a rising edge with in_valid high and in_stall low. Header words and words that
// leave a pixel incomplete are taken every cycle and give no result.
// Output channel: one pixel segment per transfer (colour, start_column,
// pixel_count, visible_count, line_end, last), taken with out_valid high and
// out_stall low. The final segment caused by a word carries last.
// A completing word is held in the run register, which feeds the result register.
// Throughput: one word per cycle while in_stall is low. A run crossing one or two
// line ends gives two or three segments, one per cycle from the run register while
// out_stall is low; a following pixel-completing word waits for the last of them.
// Stall: with out_stall high the result register holds its segment, the run
// register fills, and in_stall rises for the next word that would finish a pixel.
// Reset: parser waits for a packet header, column is 0, no segment pending; the
// registers return to 24-bit format, line width 640, visible width 640.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 format,
// 1 line width, 2 visible width); write only while no word is in flight.
module tga_rle_pixel_decoder_unit #(
	parameter int MAX_LINE_WIDTH = tgar_pkg::DEF_MAX_LINE_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [tgar_pkg::LW_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       stream_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       blue,
	output logic [7:0]                       green,
	output logic [7:0]                       red,
	output logic [tgar_pkg::COL_OUT_W-1:0]   start_column,
	output logic [tgar_pkg::CNT_W-1:0]       pixel_count,
	output logic [tgar_pkg::CNT_W-1:0]       visible_count,
	output logic                             line_end,
	output logic                             last
);

	logic [1:0]                 fmt_q;
	logic [tgar_pkg::LW_W-1:0]  lw_q;
	logic [tgar_pkg::LW_W-1:0]  vw_q;
	logic                       job_busy;
	logic                       job_load;
	tgar_pkg::job_t             job;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= tgar_pkg::RST_PIXEL_FORMAT;
			lw_q  <= tgar_pkg::RST_LINE_WIDTH;
			vw_q  <= tgar_pkg::RST_VISIBLE_WIDTH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tgar_pkg::CFG_PIXEL_FORMAT:  fmt_q <= cfg_data[1:0];
				tgar_pkg::CFG_LINE_WIDTH:    lw_q  <= cfg_data;
				tgar_pkg::CFG_VISIBLE_WIDTH: vw_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Header parser and pixel assembler
	tgar_unpack u_unpack (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.stream_byte  (stream_byte),
		.pixel_format (fmt_q),
		.job_busy     (job_busy),
		.job_load     (job_load),
		.job          (job)
	);

	// Line splitter and result register
	tgar_segment #(
		.MAX_LINE_WIDTH (MAX_LINE_WIDTH)
	) u_segment (
		.clk           (clk),
		.arst_n        (arst_n),
		.line_width    (lw_q),
		.visible_width (vw_q),
		.job_load      (job_load),
		.job           (job),
		.job_busy      (job_busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.blue          (blue),
		.green         (green),
		.red           (red),
		.start_column  (start_column),
		.pixel_count   (pixel_count),
		.visible_count (visible_count),
		.line_end      (line_end),
		.last          (last)
	);

endmodule
